### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: cond holds, then prop holds in the same cycle.
`define CI_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

### hw/rtl/ci32alu_pkg.sv
// ----------------------------------------------------------------------------
// ci32alu_pkg
// Shared widths, codes and the word type of the checked integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package ci32alu_pkg;

  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  localparam logic [DATA_WIDTH-1:0] POS_LIMIT = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // One word in flight. Non-divide words carry their final value and status;
  // divide words carry the restoring-divider state.
  typedef struct packed {
    logic                  is_div;
    logic [DATA_WIDTH-1:0] value;
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] dvs;
    logic                  qneg;
  } word_t;

endpackage

`default_nettype wire

### hw/rtl/checked_int32_alu_unit.sv
// ----------------------------------------------------------------------------
// checked_int32_alu_unit
// Overflow-checked signed add, subtract, multiply and divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i with kind_i, operand_a_i, operand_b_i; the
//   unit drives in_stall_o. Output channel: out_valid_o with value_o,
//   error_flag_o, status_o; the receiver drives out_stall_i.
//   Every input word yields exactly one output word, in order.
//   The pipe is two front stages (add / multiply, then range check), one
//   divider cell per quotient bit, and the output register. All kinds take
//   the same path. Throughput is one word per cycle while out_stall_i is
//   low; each stage holds one word and moves whenever the stage after it
//   is empty or moving.
//   When out_stall_i holds, the output word stays put and words behind it
//   keep advancing into empty stages; in_stall_o rises only once the whole
//   pipe is full.
//   Reset clears all stage valid bits; no word is in flight afterward.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module checked_int32_alu_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           kind_i,
  input  wire logic signed [ci32alu_pkg::DATA_WIDTH-1:0] operand_a_i,
  input  wire logic signed [ci32alu_pkg::DATA_WIDTH-1:0] operand_b_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [ci32alu_pkg::DATA_WIDTH-1:0] value_o,
  output logic                                      error_flag_o,
  output logic [1:0]                                status_o
);
  import ci32alu_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic          front_ready;
  logic          chain_valid [W+1];
  logic          chain_ready [W+1];
  word_t         chain_word  [W+1];
  logic [W-1:0]  value_raw;

  assign in_stall_o = !front_ready;

  ci32alu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .kind_i  (kind_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .valid_o (chain_valid[0]),
    .word_o  (chain_word[0]),
    .ready_i (chain_ready[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_cell
    ci32alu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .word_i  (chain_word[k]),
      .valid_o (chain_valid[k+1]),
      .word_o  (chain_word[k+1]),
      .ready_i (chain_ready[k+1])
    );
  end

  ci32alu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (chain_valid[W]),
    .ready_o  (chain_ready[W]),
    .word_i   (chain_word[W]),
    .valid_o  (out_valid_o),
    .value_o  (value_raw),
    .status_o (status_o),
    .ready_i  (!out_stall_i)
  );

  assign value_o      = value_raw;
  assign error_flag_o = (status_o != ST_OK);

  `CI_ASSERT_IMP(a_err_zero, out_valid_o && (status_o != ST_OK), value_o == '0,
    "error word carries a nonzero value")
  `CI_ASSERT_IMP(a_stall_hold, out_valid_o && out_stall_i, ##1 $stable(value_o),
    "stalled output word changed")
  `CI_ASSERT_IMP(a_full_stall, in_stall_o, out_valid_o && out_stall_i,
    "input stalled while output is free")

endmodule

`default_nettype wire

### hw/rtl/ci32alu_front.sv
// ----------------------------------------------------------------------------
// ci32alu_front
// Two stages: wide add and signed multiply, then range check and divide setup.
// ----------------------------------------------------------------------------
`default_nettype none

module ci32alu_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic [1:0]                        kind_i,
  input  wire logic signed [ci32alu_pkg::DATA_WIDTH-1:0] a_i,
  input  wire logic signed [ci32alu_pkg::DATA_WIDTH-1:0] b_i,
  output logic                                   valid_o,
  output ci32alu_pkg::word_t                     word_o,
  input  wire logic                              ready_i
);
  import ci32alu_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic                   s1_valid_q;
  logic [1:0]             kind_q;
  logic [W:0]             sum_q, sum_d;
  logic signed [2*W-1:0]  prod_q, prod_d;
  logic [W-1:0]           amag_q, bmag_q, amag_d, bmag_d;
  logic                   qneg_q;
  logic                   s1_ready;
  logic                   s2_ready;

  logic                   s2_valid_q;
  word_t                  word_q, word_d;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  always_comb begin
    if (kind_i == KIND_SUB) begin
      sum_d = {a_i[W-1], a_i} - {b_i[W-1], b_i};
    end else begin
      sum_d = {a_i[W-1], a_i} + {b_i[W-1], b_i};
    end
    prod_d = a_i * b_i;
    amag_d = a_i[W-1] ? (~a_i + 1'b1) : a_i;
    bmag_d = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      kind_q <= kind_i;
      sum_q  <= sum_d;
      prod_q <= prod_d;
      amag_q <= amag_d;
      bmag_q <= bmag_d;
      qneg_q <= a_i[W-1] ^ b_i[W-1];
    end
  end

  always_comb begin
    word_d        = '0;
    word_d.status = ST_OK;
    case (kind_q)
      KIND_ADD, KIND_SUB: begin
        if (sum_q[W] == sum_q[W-1]) begin
          word_d.value = sum_q[W-1:0];
        end else begin
          word_d.status = sum_q[W] ? ST_UNDER : ST_OVER;
        end
      end
      KIND_MUL: begin
        if (&prod_q[2*W-1:W-1] || ~|prod_q[2*W-1:W-1]) begin
          word_d.value = prod_q[W-1:0];
        end else begin
          word_d.status = prod_q[2*W-1] ? ST_UNDER : ST_OVER;
        end
      end
      default: begin
        if (bmag_q == '0) begin
          word_d.status = ST_DIVZ;
        end else begin
          word_d.is_div = 1'b1;
          word_d.quo    = amag_q;
          word_d.dvs    = bmag_q;
          word_d.qneg   = qneg_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      word_q <= word_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

### hw/rtl/ci32alu_cell.sv
// ----------------------------------------------------------------------------
// ci32alu_cell
// One restoring-divide step per cell; non-divide words pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module ci32alu_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire ci32alu_pkg::word_t word_i,
  output logic                    valid_o,
  output ci32alu_pkg::word_t      word_o,
  input  wire logic               ready_i
);
  import ci32alu_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic       valid_q;
  word_t      word_q, word_d;
  logic [W:0] trial, diff;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    word_d = word_i;
    trial  = {word_i.rem, word_i.quo[W-1]};
    diff   = trial - {1'b0, word_i.dvs};
    if (word_i.is_div) begin
      if (!diff[W]) begin
        word_d.rem = diff[W-1:0];
        word_d.quo = {word_i.quo[W-2:0], 1'b1};
      end else begin
        word_d.rem = trial[W-1:0];
        word_d.quo = {word_i.quo[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

### hw/rtl/ci32alu_back.sv
// ----------------------------------------------------------------------------
// ci32alu_back
// Output register: signs the quotient and flags the one divide overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module ci32alu_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire ci32alu_pkg::word_t            word_i,
  output logic                               valid_o,
  output logic [ci32alu_pkg::DATA_WIDTH-1:0] value_o,
  output logic [1:0]                         status_o,
  input  wire logic                          ready_i
);
  import ci32alu_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic         valid_q;
  logic [W-1:0] value_q, value_d;
  logic [1:0]   status_q, status_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    value_d  = word_i.value;
    status_d = word_i.status;
    if (word_i.is_div) begin
      if (word_i.qneg) begin
        value_d = ~word_i.quo + 1'b1;
      end else if (word_i.quo > POS_LIMIT) begin
        value_d  = '0;
        status_d = ST_OVER;
      end else begin
        value_d = word_i.quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

### dv/alu_checker.sv
// ----------------------------------------------------------------------------
// alu_checker
// Watches both channels of the checked ALU, predicts each result word from
// the accepted input word and compares it field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_checker (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  input  wire logic                                  in_stall_i,
  input  wire logic [1:0]                            kind_i,
  input  wire logic [ci32alu_pkg::DATA_WIDTH-1:0]    operand_a_i,
  input  wire logic [ci32alu_pkg::DATA_WIDTH-1:0]    operand_b_i,
  input  wire logic                                  out_valid_i,
  input  wire logic                                  out_stall_i,
  input  wire logic [ci32alu_pkg::DATA_WIDTH-1:0]    value_i,
  input  wire logic                                  error_flag_i,
  input  wire logic [1:0]                            status_i,
  output int                                         fail_count_o,
  output int                                         pending_o
);
  import ci32alu_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  error_flag;
    logic [1:0]            status;
  } alu_result_t;

  alu_result_t result_q[$];

  // Exact result computed at double width plus margin, then range checked.
  function automatic alu_result_t compute_result(logic [1:0] kind,
                                                 logic [DATA_WIDTH-1:0] a,
                                                 logic [DATA_WIDTH-1:0] b);
    logic signed [2*DATA_WIDTH+1:0] sa, sb, exact;
    logic signed [2*DATA_WIDTH+1:0] max_v, min_v;
    alu_result_t r;
    sa = $signed(a);
    sb = $signed(b);
    max_v = $signed({1'b0, POS_LIMIT});
    min_v = -max_v - 1;
    r = '0;
    case (kind)
      KIND_ADD: exact = sa + sb;
      KIND_SUB: exact = sa - sb;
      KIND_MUL: exact = sa * sb;
      default: begin
        if (sb == 0) begin
          r.error_flag = 1'b1;
          r.status = ST_DIVZ;
          return r;
        end
        exact = sa / sb;
      end
    endcase
    if (exact > max_v) r.status = ST_OVER;
    else if (exact < min_v) r.status = ST_UNDER;
    else r.value = exact[DATA_WIDTH-1:0];
    r.error_flag = (r.status != ST_OK);
    return r;
  endfunction

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(compute_result(kind_i, operand_a_i, operand_b_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result word");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.value !== value_i || exp_r.error_flag !== error_flag_i ||
              exp_r.status !== status_i) begin
            if (fail_count_o < 10) begin
              $display("ERROR: exp value %h err %b st %0d, got %h err %b st %0d",
                       exp_r.value, exp_r.error_flag, exp_r.status,
                       value_i, error_flag_i, status_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operations into the checked ALU with random
// idling on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ci32alu_pkg::*;

  localparam int LATENCY = DATA_WIDTH + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 400;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    kind_i = KIND_ADD;
  logic signed [DATA_WIDTH-1:0]  operand_a_i = '0;
  logic signed [DATA_WIDTH-1:0]  operand_b_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [DATA_WIDTH-1:0]  value_o;
  logic                          error_flag_o;
  logic [1:0]                    status_o;
  int                            fail_count;
  int                            pending;
  int                            cycle_count = 0;
  bit                            quiet_phase = 1'b0;
  bit                            hold_off = 1'b0;

  localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  checked_int32_alu_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .operand_a_i,
    .operand_b_i, .out_valid_o, .out_stall_i, .value_o, .error_flag_o, .status_o
  );

  alu_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i,
    .operand_a_i, .operand_b_i, .out_valid_i(out_valid_o), .out_stall_i,
    .value_i(value_o), .error_flag_i(error_flag_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stall: random bursts, a long hold-off, none in the quiet phase.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (120) @(negedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(logic [1:0] kind, logic [DATA_WIDTH-1:0] a,
                           logic [DATA_WIDTH-1:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_operand();
    case ($urandom_range(0, 5))
      0: return MIN_V + $urandom_range(0, 3);
      1: return POS_LIMIT - $urandom_range(0, 3);
      2: return $urandom_range(0, 8) - 4;
      3: return $signed(16'($urandom()));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [DATA_WIDTH-1:0] a, b;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_word(KIND_ADD, POS_LIMIT, 1);
    send_word(KIND_ADD, MIN_V, '1);
    send_word(KIND_ADD, MIN_V, POS_LIMIT);
    send_word(KIND_ADD, POS_LIMIT, POS_LIMIT);
    send_word(KIND_ADD, MIN_V, MIN_V);
    send_word(KIND_SUB, MIN_V, 1);
    send_word(KIND_SUB, '1, POS_LIMIT);
    send_word(KIND_SUB, 0, MIN_V);
    send_word(KIND_SUB, '1, MIN_V);
    send_word(KIND_SUB, POS_LIMIT, '1);
    send_word(KIND_MUL, MIN_V, 1);
    send_word(KIND_MUL, MIN_V, '1);
    send_word(KIND_MUL, 32'h0001_0000, 32'hFFFF_8000);
    send_word(KIND_MUL, 32'h0001_0000, 32'h0000_8000);
    send_word(KIND_MUL, 0, MIN_V);
    send_word(KIND_MUL, POS_LIMIT, POS_LIMIT);
    send_word(KIND_DIV, MIN_V, '1);
    send_word(KIND_DIV, MIN_V, 1);
    send_word(KIND_DIV, 5, 0);
    send_word(KIND_DIV, 0, 0);
    send_word(KIND_DIV, -7, 2);
    send_word(KIND_DIV, 1, -2);
    send_word(KIND_DIV, POS_LIMIT, MIN_V);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_off = 1'b1;
      if (i == 250) begin
        in_valid_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      if (i == 330) quiet_phase = 1'b1;
      a = random_operand();
      b = random_operand();
      send_word(2'($urandom_range(0, 3)), a, b);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/ci32alu_pkg.sv
hw/rtl/ci32alu_front.sv
hw/rtl/ci32alu_cell.sv
hw/rtl/ci32alu_back.sv
hw/rtl/checked_int32_alu_unit.sv
dv/alu_checker.sv
dv/testbench.sv
